FILE: design/lqmr_pkg.sv
// ----------------------------------------------------------------------------
// lqmr_pkg: shared definitions for the linear queue with max and reverse read
// Sizes, operation codes and status codes used by the queue logic.
// ----------------------------------------------------------------------------
package lqmr_pkg;

    // Number of entries in the value store.
    localparam int DEPTH       = 32;
    // Largest number of entries that one reverse read may return.
    localparam int MAX_RESULTS = 32;

    // Field widths.
    localparam int DATA_W   = 32;
    localparam int OP_W     = 2;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;

    // Store address and fill counter widths.
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    // Width used to compare a requested count against the fill counter.
    localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUT = 2'd0;
    localparam logic [OP_W-1:0] OP_GET = 2'd1;
    localparam logic [OP_W-1:0] OP_REV = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_SHORT     = 2'd3;

endpackage

FILE: design/linear_queue_with_max_and_reverse_read_top.sv
// ----------------------------------------------------------------------------
// linear_queue_with_max_and_reverse_read_top: non-circular queue with maximum
// A linear store of signed values with get, reverse read and a running max.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_stall, op, value, count) carries one
// command per transaction: put a value, get the oldest unread value, or read
// back the newest count values, newest first. The output channel (out_valid,
// out_stall, data, status, largest, largest_valid, last) carries one result
// per transaction; last marks the final result of a command.
// A put, or any command that ends in an error status, shows its result in the
// cycle after it is taken, so puts run at one per cycle while out_stall is low.
// A get reads the synchronous store into its read register, then into the
// output register. A reverse read moves its first entry the same way, then one
// entry per cycle while out_stall is low, paced by the single read port of the
// store. A reverse read of zero entries and the unused op code give no result.
// The block takes a new command only when no earlier command is still
// reading and the output register is free or being emptied in that cycle.
// When the receiver stalls, the output register holds its result and the
// block waits. Reset empties the queue and clears the running maximum; the
// store contents are not cleared and are only read where written.
// ----------------------------------------------------------------------------
module linear_queue_with_max_and_reverse_read_top
    import lqmr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    // Command channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic        [OP_W-1:0]     op,
    input  logic signed [DATA_W-1:0]   value,
    input  logic        [COUNT_W-1:0]  count,
    // Result channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [DATA_W-1:0]   data,
    output logic        [STATUS_W-1:0] status,
    output logic signed [DATA_W-1:0]   largest,
    output logic                       largest_valid,
    output logic                       last
);

    // Sequencer state codes.
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_GET  = 2'd1;
    localparam logic [1:0] S_REV  = 2'd2;

    // Control registers.
    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   put_count_reg, put_count_next;
    logic [CNT_W-1:0]   get_count_reg, get_count_next;
    logic [ADDR_W-1:0]  rptr_reg, rptr_next;
    logic [COUNT_W-1:0] rem_reg, rem_next;
    logic               out_valid_reg, out_valid_next;

    // Running maximum and output payload registers.
    logic signed [DATA_W-1:0] max_reg, max_next;
    logic signed [DATA_W-1:0] data_reg, data_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic signed [DATA_W-1:0] largest_reg, largest_next;
    logic                     lvalid_reg, lvalid_next;
    logic                     last_reg, last_next;

    // Store and its ports.
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    // Handshake helpers.
    logic out_free;
    logic in_take;
    logic full;
    logic too_many;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;
    assign in_take  = in_valid && !in_stall;
    assign full     = (put_count_reg == CNT_W'(DEPTH));
    assign too_many = (CMP_W'(count) > CMP_W'(put_count_reg))
                   || (count > COUNT_W'(MAX_RESULTS));

    // Command sequencing, store access and result formation.
    always_comb
    begin
        state_next     = state_reg;
        put_count_next = put_count_reg;
        get_count_next = get_count_reg;
        rptr_next      = rptr_reg;
        rem_next       = rem_reg;
        max_next       = max_reg;
        out_valid_next = out_valid_reg && out_stall;
        data_next      = data_reg;
        status_next    = status_reg;
        largest_next   = largest_reg;
        lvalid_next    = lvalid_reg;
        last_next      = last_reg;
        wr_en          = 1'b0;
        wr_addr        = put_count_reg[ADDR_W-1:0];
        rd_en          = 1'b0;
        rd_addr        = rptr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    case (op)
                        OP_PUT:
                        begin
                            out_valid_next = 1'b1;
                            data_next      = '0;
                            last_next      = 1'b1;
                            if (full)
                            begin
                                status_next  = STAT_FULL;
                                largest_next = max_reg;
                                lvalid_next  = (put_count_reg != '0);
                            end
                            else
                            begin
                                // Append and fold the value into the maximum.
                                wr_en          = 1'b1;
                                put_count_next = put_count_reg + CNT_W'(1);
                                if ((put_count_reg == '0) || (value > max_reg))
                                begin
                                    max_next = value;
                                end
                                status_next  = STAT_OK;
                                largest_next = max_next;
                                lvalid_next  = 1'b1;
                            end
                        end
                        OP_GET:
                        begin
                            if (get_count_reg >= put_count_reg)
                            begin
                                out_valid_next = 1'b1;
                                data_next      = '0;
                                status_next    = STAT_UNDERFLOW;
                                largest_next   = max_reg;
                                lvalid_next    = (put_count_reg != '0);
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                rd_en          = 1'b1;
                                rd_addr        = get_count_reg[ADDR_W-1:0];
                                get_count_next = get_count_reg + CNT_W'(1);
                                state_next     = S_GET;
                            end
                        end
                        OP_REV:
                        begin
                            if (count == '0)
                            begin
                                state_next = S_IDLE;
                            end
                            else if (too_many)
                            begin
                                out_valid_next = 1'b1;
                                data_next      = '0;
                                status_next    = STAT_SHORT;
                                largest_next   = max_reg;
                                lvalid_next    = (put_count_reg != '0);
                                last_next      = 1'b1;
                            end
                            else
                            begin
                                // Start at the newest entry and walk downward.
                                rd_en      = 1'b1;
                                rd_addr    = ADDR_W'(put_count_reg - CNT_W'(1));
                                rptr_next  = ADDR_W'(put_count_reg - CNT_W'(2));
                                rem_next   = count;
                                state_next = S_REV;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_GET:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    data_next      = rd_data_reg;
                    status_next    = STAT_OK;
                    largest_next   = max_reg;
                    lvalid_next    = 1'b1;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_REV:
            begin
                // Hand out the entry in the read register and fetch the next one unless it is the last.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    data_next      = rd_data_reg;
                    status_next    = STAT_OK;
                    largest_next   = max_reg;
                    lvalid_next    = 1'b1;
                    last_next      = (rem_reg == COUNT_W'(1));
                    if (rem_reg == COUNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_en     = 1'b1;
                        rd_addr   = rptr_reg;
                        rptr_next = rptr_reg - ADDR_W'(1);
                        rem_next  = rem_reg - COUNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            put_count_reg <= '0;
            get_count_reg <= '0;
            rptr_reg      <= '0;
            rem_reg       <= '0;
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            put_count_reg <= put_count_next;
            get_count_reg <= get_count_next;
            rptr_reg      <= rptr_next;
            rem_reg       <= rem_next;
            max_reg       <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output payload registers.
    always_ff @(posedge clk)
    begin
        data_reg    <= data_next;
        status_reg  <= status_next;
        largest_reg <= largest_next;
        lvalid_reg  <= lvalid_next;
        last_reg    <= last_next;
    end

    // Value store: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Result channel outputs.
    assign out_valid     = out_valid_reg;
    assign data          = data_reg;
    assign status        = status_reg;
    assign largest       = largest_reg;
    assign largest_valid = lvalid_reg;
    assign last          = last_reg;

endmodule
